// ===== hdl/oost_pkg.sv =====
// Shared types and constants of the owned object slot table.
package oost_pkg;

   typedef enum logic [1:0] {
      KIND_STORE    = 2'd0,
      KIND_RETRIEVE = 2'd1,
      KIND_REMOVE   = 2'd2,
      KIND_CLEANUP  = 2'd3
   } oost_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_SIZE    = 2'd2,
      ST_FULL    = 2'd3
   } oost_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN
   } oost_state_type;

   typedef struct packed {
      logic            valid;
      oost_status_type status;
      logic [3:0]      slot;
   } oost_rsp_type;

   localparam logic [0:0] CSR_KERNEL_ID = 1'b0;
   localparam logic [0:0] CSR_NONE_ID   = 1'b1;

   localparam logic [7:0] KERNEL_ID_RESET = 8'd0;
   localparam logic [7:0] NONE_ID_RESET   = 8'd255;

endpackage

// ===== hdl/oost_mem.sv =====
// Slot memory: owner and size per slot, one read and one write port, with valid bits.
module oost_mem #(
   parameter int SLOTS = 16,
   parameter int OW    = 8,
   parameter int SW    = 14,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [OW-1:0] rd_owner,
   output logic [SW-1:0] rd_size,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [OW-1:0] wr_owner,
   input  logic [SW-1:0] wr_size
);
   import oost_pkg::*;

   logic [OW+SW-1:0] mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [OW+SW-1:0] data_ff;
   logic             vld_ff;
   logic [OW+7:0]    reset_owner_wide;
   logic [OW-1:0]    reset_owner;

   // A slot never written reads as free and owned by the reset none id.
   assign reset_owner_wide = {{OW{1'b0}}, NONE_ID_RESET};
   assign reset_owner      = reset_owner_wide[OW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_owner, wr_size};
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_owner = vld_ff ? data_ff[OW+SW-1:SW] : reset_owner;
   assign rd_size  = vld_ff ? data_ff[SW-1:0] : '0;

endmodule

// ===== hdl/oost_ctrl.sv =====
// Request sequencer: checks, slot scan and read-modify-write of the slot memory.
module oost_ctrl #(
   parameter int SLOTS     = 16,
   parameter int MAX_BYTES = 8192,
   parameter int OW        = 8,
   parameter int SW        = 14,
   parameter int AW        = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  oost_pkg::oost_kind_type req_kind,
   input  logic [7:0]             req_owner,
   input  logic                   req_owner_alive,
   input  logic [7:0]             req_handle,
   input  logic [15:0]            req_size_bytes,
   input  logic [7:0]             kernel_id,
   input  logic [7:0]             none_id,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  logic [OW-1:0]          rd_owner,
   input  logic [SW-1:0]          rd_size,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [OW-1:0]          wr_owner,
   output logic [SW-1:0]          wr_size,
   output oost_pkg::oost_rsp_type rsp
);
   import oost_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);

   function automatic logic [OW-1:0] to_owner(input logic [7:0] v);
      logic [OW+7:0] t;
      t = {{OW{1'b0}}, v};
      return t[OW-1:0];
   endfunction

   oost_state_type state_ff, state_in;
   oost_kind_type  kind_ff;
   logic [OW-1:0]  owner_ff;
   logic           alive_ff;
   logic [7:0]     handle_ff;
   logic [15:0]    size_ff;
   logic [CW-1:0]  nxt_ff, nxt_in;
   logic           eval_ff;
   logic [AW-1:0]  eval_addr_ff;

   logic           accept;
   logic           owner_hit;
   logic           last;
   logic           handle_bad;
   logic           alive_ok;
   logic           scan_kind;
   logic [AW+3:0]  eval_slot_wide;

   assign accept         = start && (state_ff == S_IDLE);
   assign busy           = (state_ff != S_IDLE);
   assign owner_hit      = (rd_owner == owner_ff);
   assign last           = (eval_addr_ff == AW'(SLOTS - 1));
   assign handle_bad     = ({1'b0, handle_ff} >= 9'(SLOTS));
   assign alive_ok       = alive_ff || (owner_ff == to_owner(kernel_id));
   assign scan_kind      = (kind_ff == KIND_STORE) || (kind_ff == KIND_CLEANUP);
   assign eval_slot_wide = {4'b0000, eval_addr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eval_ff  <= 1'b0;
         nxt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         eval_ff  <= rd_en;
         nxt_ff   <= nxt_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_addr_ff <= rd_addr;
      if (accept) begin
         kind_ff   <= req_kind;
         owner_ff  <= to_owner(req_owner);
         alive_ff  <= req_owner_alive;
         handle_ff <= req_handle;
         size_ff   <= req_size_bytes;
      end
   end

   always_comb begin
      state_in   = state_ff;
      nxt_in     = nxt_ff;
      rd_en      = 1'b0;
      rd_addr    = nxt_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = eval_addr_ff;
      wr_owner   = to_owner(none_id);
      wr_size    = '0;
      rsp.valid  = 1'b0;
      rsp.status = ST_OK;
      rsp.slot   = 4'd0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            case (kind_ff)
               KIND_STORE: begin
                  if (size_ff == 16'd0) begin
                     rsp.valid  = 1'b1;
                     rsp.status = ST_INVALID;
                     state_in   = S_IDLE;
                  end else if (size_ff > 16'(MAX_BYTES)) begin
                     rsp.valid  = 1'b1;
                     rsp.status = ST_SIZE;
                     state_in   = S_IDLE;
                  end else if (!alive_ok) begin
                     rsp.valid  = 1'b1;
                     rsp.status = ST_INVALID;
                     state_in   = S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     nxt_in   = CW'(1);
                     state_in = S_SCAN;
                  end
               end
               KIND_CLEANUP: begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  nxt_in   = CW'(1);
                  state_in = S_SCAN;
               end
               KIND_RETRIEVE, KIND_REMOVE: begin
                  if (handle_bad) begin
                     rsp.valid  = 1'b1;
                     rsp.status = ST_INVALID;
                     rsp.slot   = handle_ff[3:0];
                     state_in   = S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = handle_ff[AW-1:0];
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SCAN: begin
            // Keep the read pipe full: slot i+1 is read while slot i is judged.
            if (scan_kind && (nxt_ff < CW'(SLOTS))) begin
               rd_en   = 1'b1;
               rd_addr = nxt_ff[AW-1:0];
               nxt_in  = nxt_ff + CW'(1);
            end
            if (eval_ff) begin
               case (kind_ff)
                  KIND_STORE: begin
                     if (rd_size == '0) begin
                        wr_en      = 1'b1;
                        wr_owner   = owner_ff;
                        wr_size    = size_ff[SW-1:0];
                        rsp.valid  = 1'b1;
                        rsp.status = ST_OK;
                        rsp.slot   = eval_slot_wide[3:0];
                        state_in   = S_IDLE;
                     end else if (last) begin
                        rsp.valid  = 1'b1;
                        rsp.status = ST_FULL;
                        state_in   = S_IDLE;
                     end
                  end
                  KIND_RETRIEVE: begin
                     rsp.valid  = 1'b1;
                     rsp.status = (owner_hit && (16'(rd_size) == size_ff)) ? ST_OK : ST_INVALID;
                     rsp.slot   = handle_ff[3:0];
                     state_in   = S_IDLE;
                  end
                  KIND_REMOVE: begin
                     wr_en      = owner_hit;
                     rsp.valid  = 1'b1;
                     rsp.status = owner_hit ? ST_OK : ST_INVALID;
                     rsp.slot   = handle_ff[3:0];
                     state_in   = S_IDLE;
                  end
                  KIND_CLEANUP: begin
                     wr_en = owner_hit;
                     if (last) begin
                        rsp.valid = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/owned_object_slot_table_core.sv =====
// Top level of the owned object slot table: registers, result beat and memory hookup.
//
// The table holds SLOTS slots of owner id and byte size, kept in one synchronous memory
// with a registered read, and serves one request at a time. A request beat is taken when
// start is high while busy is low; its single result beat appears on rsp_status and
// rsp_slot for exactly one cycle with rsp_strobe high, and the receiver has no way to
// hold it off, so it must take it in that cycle. A store or a cleanup walks the memory
// one slot per cycle through the single read port; a store ends early at the first free
// slot, and a store that fails its size or owner checks answers from the check state
// without any read. A retrieve or remove reads the slot named by its handle and answers
// from that read, or answers from the check state when the handle is out of range. A
// new request can be accepted in the cycle that carries the previous result. Reset
// clears the per-slot valid bits at once, so the table is usable the cycle after reset
// with no clearing pass. The kernel and none owner registers are written through the
// csr port; they must be written only while the block is idle, which the block itself
// does not enforce. A new none id affects slots freed afterwards only.
module owned_object_slot_table_core #(
   parameter int SLOTS      = 16,
   parameter int MAX_BYTES  = 8192,
   parameter int OWNER_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  oost_pkg::oost_kind_type   req_kind,
   input  logic [7:0]               req_owner,
   input  logic                     req_owner_alive,
   input  logic [7:0]               req_handle,
   input  logic [15:0]              req_size_bytes,
   output logic                     rsp_strobe,
   output oost_pkg::oost_status_type rsp_status,
   output logic [3:0]               rsp_slot,
   input  logic                     csr_we,
   input  logic [0:0]               csr_index,
   input  logic [7:0]               csr_wdata
);
   import oost_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int SW = $clog2(MAX_BYTES + 1);
   localparam int OW = OWNER_BITS;

   logic [7:0]   kernel_id_ff;
   logic [7:0]   none_id_ff;
   oost_rsp_type rsp;
   oost_rsp_type rsp_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [OW-1:0] rd_owner;
   logic [SW-1:0] rd_size;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [OW-1:0] wr_owner;
   logic [SW-1:0] wr_size;

   // Owner registers. Writes must arrive only while the table is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_id_ff <= KERNEL_ID_RESET;
         none_id_ff   <= NONE_ID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KERNEL_ID: kernel_id_ff <= csr_wdata;
            CSR_NONE_ID:   none_id_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The result beat is registered so that it lasts exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp.valid;
      end
      rsp_ff.status <= rsp.status;
      rsp_ff.slot   <= rsp.slot;
   end

   assign rsp_strobe = rsp_ff.valid;
   assign rsp_status = rsp_ff.status;
   assign rsp_slot   = rsp_ff.slot;

   oost_ctrl #(
      .SLOTS    (SLOTS),
      .MAX_BYTES(MAX_BYTES),
      .OW       (OW),
      .SW       (SW),
      .AW       (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_owner      (req_owner),
      .req_owner_alive(req_owner_alive),
      .req_handle     (req_handle),
      .req_size_bytes (req_size_bytes),
      .kernel_id      (kernel_id_ff),
      .none_id        (none_id_ff),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_owner       (rd_owner),
      .rd_size        (rd_size),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_owner       (wr_owner),
      .wr_size        (wr_size),
      .rsp            (rsp)
   );

   oost_mem #(
      .SLOTS(SLOTS),
      .OW   (OW),
      .SW   (SW),
      .AW   (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_owner(rd_owner),
      .rd_size (rd_size),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_owner(wr_owner),
      .wr_size (wr_size)
   );

endmodule

// ===== hdl/oost_chk.sv =====
// Port-level checker of the owned object slot table and its bind statement.
module oost_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input oost_pkg::oost_status_type rsp_status,
   input logic [3:0]                rsp_slot
);
   import oost_pkg::*;

   // An accepted request always makes the block busy in the cycle after it is taken.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // The result beat is shown only once the block is free again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // One request gives one beat, so beats never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in a row");

   // A full table returns slot zero.
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> (rsp_slot == 4'd0))
      else $error("table full beat with nonzero slot");

endmodule

bind owned_object_slot_table_core oost_chk u_oost_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_status(rsp_status),
   .rsp_slot  (rsp_slot)
);
